// ===== src/clnws_pkg.sv =====
// Shared types, constants and tables for the character LCD nibble write sequencer.
package clnws_pkg;

   // request and response payloads
   typedef struct packed {
      logic [1:0] mode;
      logic [7:0] row;
      logic [7:0] col;
      logic [7:0] char_code;
   } req_type;

   typedef struct packed {
      logic       reg_select;
      logic [3:0] nibble;
      logic       last;
   } rsp_type;

   // nibble from the generator towards the output register
   typedef struct packed {
      logic    valid;
      rsp_type data;
   } nib_type;

   // request modes
   localparam logic [1:0] MODE_INIT       = 2'd0;
   localparam logic [1:0] MODE_SET_POS    = 2'd1;
   localparam logic [1:0] MODE_WRITE_CHAR = 2'd2;

   // register select codes
   localparam logic RS_INSTR = 1'b0;
   localparam logic RS_DATA  = 1'b1;

   // configuration register indexes
   localparam int           CSR_INDEX_W   = 1;
   localparam int           CSR_DATA_W    = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TWO_LINES = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TALL_FONT = 1'd1;

   // display geometry
   localparam int COLS_DEFAULT = 16;
   localparam logic [7:0] WRAP_HOME_COL = 8'd32;
   localparam logic [7:0] ROW_TWO       = 8'd1;

   // instruction bytes
   localparam logic [3:0] NIB_WAKE      = 4'h2;
   localparam logic [7:0] CMD_FUNC_SET  = 8'b0010_0000;
   localparam logic [7:0] FS_TWO_LINES  = 8'b0000_1000;
   localparam logic [7:0] FS_TALL_FONT  = 8'b0000_0100;
   localparam logic [7:0] CMD_DISP_ON   = 8'b0000_1110;
   localparam logic [7:0] CMD_ENTRY     = 8'b0000_0110;
   localparam logic [7:0] CMD_CLEAR     = 8'b0000_0001;
   localparam logic [7:0] CMD_CGRAM     = 8'b0100_0000;
   localparam logic [7:0] CMD_DDRAM     = 8'b1000_0000;
   localparam logic [7:0] ROW_TWO_BASE  = 8'h40;

   // init sequence step layout
   localparam int STEP_W = 6;
   localparam logic [STEP_W-1:0] INIT_GLYPH_STEP = 6'd9;
   localparam logic [STEP_W-1:0] INIT_LAST_STEP  = 6'd44;

   // battery glyph, one row of five pixels per CGRAM address
   function automatic logic [7:0] glyph_row(input logic [3:0] idx);
      logic [7:0] r;
      case (idx)
         4'd0:                         r = 8'h0E;
         4'd1, 4'd7:                   r = 8'h1F;
         4'd2, 4'd3, 4'd4, 4'd5, 4'd6: r = 8'h11;
         default:                      r = 8'h00;
      endcase
      return r;
   endfunction

endpackage

// ===== src/clnws_req_reg.sv =====
// Request holding register: keeps one request until the generator is done with it.
module clnws_req_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  clnws_pkg::req_type req_data,
   input  logic              done,
   output logic              item_valid,
   output clnws_pkg::req_type item_data
);

   logic              valid_ff, valid_in;
   clnws_pkg::req_type data_ff;
   logic              accept;

   // a new request may enter in the cycle the held one finishes
   assign req_stall = valid_ff && !done;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         valid_in = 1'b1;
      end else if (done) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= req_data;
      end
   end

   assign item_valid = valid_ff;
   assign item_data  = data_ff;

endmodule

// ===== src/clnws_gen.sv =====
// Nibble generator: step counter, tracked cursor, config bits and nibble selection.
module clnws_gen #(
   parameter int COLS = clnws_pkg::COLS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [clnws_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [clnws_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                                item_valid,
   input  clnws_pkg::req_type                  item_data,
   input  logic                                take,
   output clnws_pkg::nib_type                  nib,
   output logic                                done
);

   logic                           two_lines_ff, tall_font_ff;
   logic [clnws_pkg::STEP_W-1:0]   step_ff, step_in;
   logic [7:0]                     row_ff, row_in, col_ff, col_in;
   logic [7:0]                     col_inc, new_row, new_col;
   logic                           wrap_cols, wrap_home, wrap;
   logic [7:0]                     cur_row, cur_col, cur_byte;
   logic [7:0]                     fs_byte, init_byte;
   logic [clnws_pkg::STEP_W-1:0]   k_cmd, k_glyph, last_step;
   logic [7:0]                     sel_byte;
   logic                           sel_rs, sel_lo, has_out;
   logic [3:0]                     sel_nib;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         two_lines_ff <= 1'b1;
         tall_font_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            clnws_pkg::CSR_TWO_LINES: two_lines_ff <= csr_wdata[0];
            clnws_pkg::CSR_TALL_FONT: tall_font_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // cursor advance after a character
   assign col_inc   = col_ff + 8'd1;
   assign wrap_cols = (col_inc == 8'(COLS));
   assign wrap_home = !wrap_cols && (col_inc == clnws_pkg::WRAP_HOME_COL);
   assign wrap      = wrap_cols || wrap_home;

   always_comb begin
      if (wrap_cols) begin
         new_col = 8'd0;
         new_row = row_ff + 8'd1;
      end else if (wrap_home) begin
         new_col = 8'd0;
         new_row = 8'd0;
      end else begin
         new_col = col_inc;
         new_row = row_ff;
      end
   end

   // cursor command for the position this request leaves behind
   always_comb begin
      if (item_data.mode == clnws_pkg::MODE_SET_POS) begin
         cur_row = item_data.row;
         cur_col = item_data.col;
      end else begin
         cur_row = new_row;
         cur_col = new_col;
      end
      cur_byte = clnws_pkg::CMD_DDRAM | (cur_col +
                 ((cur_row == clnws_pkg::ROW_TWO) ? clnws_pkg::ROW_TWO_BASE : 8'd0));
   end

   // function set with the configured bits
   assign fs_byte = clnws_pkg::CMD_FUNC_SET
                  | (two_lines_ff ? clnws_pkg::FS_TWO_LINES : 8'd0)
                  | (tall_font_ff ? clnws_pkg::FS_TALL_FONT : 8'd0);

   assign k_cmd   = step_ff - 6'd1;
   assign k_glyph = step_ff - clnws_pkg::INIT_GLYPH_STEP;

   always_comb begin
      case (k_cmd[2:1])
         2'd0:    init_byte = fs_byte;
         2'd1:    init_byte = clnws_pkg::CMD_DISP_ON;
         2'd2:    init_byte = clnws_pkg::CMD_ENTRY;
         default: init_byte = clnws_pkg::CMD_CLEAR;
      endcase
   end

   // byte, register select and half for the current step
   always_comb begin
      sel_byte  = 8'd0;
      sel_rs    = clnws_pkg::RS_INSTR;
      sel_lo    = step_ff[0];
      last_step = 6'd1;
      has_out   = 1'b1;
      unique case (item_data.mode)
         clnws_pkg::MODE_INIT: begin
            last_step = clnws_pkg::INIT_LAST_STEP;
            if (step_ff == 6'd0) begin
               sel_byte = {4'd0, clnws_pkg::NIB_WAKE};
               sel_lo   = 1'b1;
            end else if (step_ff < clnws_pkg::INIT_GLYPH_STEP) begin
               sel_byte = init_byte;
               sel_lo   = k_cmd[0];
            end else begin
               sel_lo = k_glyph[0];
               if (k_glyph[1]) begin
                  sel_rs   = clnws_pkg::RS_DATA;
                  sel_byte = clnws_pkg::glyph_row(k_glyph[5:2]);
               end else begin
                  sel_byte = clnws_pkg::CMD_CGRAM | {4'd0, k_glyph[5:2]};
               end
            end
         end
         clnws_pkg::MODE_SET_POS: begin
            sel_byte = cur_byte;
         end
         clnws_pkg::MODE_WRITE_CHAR: begin
            last_step = wrap ? 6'd3 : 6'd1;
            if (step_ff[1]) begin
               sel_byte = cur_byte;
            end else begin
               sel_rs   = clnws_pkg::RS_DATA;
               sel_byte = item_data.char_code;
            end
         end
         default: begin
            has_out = 1'b0;
         end
      endcase
      sel_nib = sel_lo ? sel_byte[3:0] : sel_byte[7:4];
   end

   assign nib.valid           = item_valid && has_out;
   assign nib.data.reg_select = sel_rs;
   assign nib.data.nibble     = sel_nib;
   assign nib.data.last       = (step_ff == last_step);

   // unused mode is dropped at once
   assign done = item_valid && (!has_out || (take && (step_ff == last_step)));

   // step counter
   always_comb begin
      if (done) begin
         step_in = '0;
      end else if (nib.valid && take) begin
         step_in = step_ff + 6'd1;
      end else begin
         step_in = step_ff;
      end
   end

   // tracked cursor, committed as the request finishes
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (done) begin
         case (item_data.mode)
            clnws_pkg::MODE_INIT: begin
               row_in = 8'd0;
               col_in = 8'd0;
            end
            clnws_pkg::MODE_SET_POS: begin
               row_in = item_data.row;
               col_in = item_data.col;
            end
            clnws_pkg::MODE_WRITE_CHAR: begin
               row_in = new_row;
               col_in = new_col;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         row_ff  <= 8'd0;
         col_ff  <= 8'd0;
      end else begin
         step_ff <= step_in;
         row_ff  <= row_in;
         col_ff  <= col_in;
      end
   end

endmodule

// ===== src/clnws_out_reg.sv =====
// Response register: holds one nibble transfer while the receiver stalls.
module clnws_out_reg (
   input  logic               clock,
   input  logic               reset,
   input  clnws_pkg::nib_type nib,
   output logic               take,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output clnws_pkg::rsp_type rsp_data
);

   logic               valid_ff;
   clnws_pkg::rsp_type data_ff;

   // load whenever empty or the held nibble leaves
   assign take = !valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= nib.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         data_ff <= nib.data;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

// ===== src/char_lcd_nibble_write_sequencer.sv =====
// Top level of the character LCD nibble write sequencer.
// Requests arrive on req_valid/req_stall with req_data (mode, row, col, char_code).
// Each request turns into nibble transfers on rsp_valid/rsp_stall with rsp_data
// (reg_select, nibble, last); last marks the final nibble of a request.
// csr_we/csr_index/csr_wdata write two_lines (index 0) and tall_font (index 1);
// the user must write them only while the block is idle; the block does not enforce it.
// The first nibble of a request passes through the request register and then the
// response register before it shows on rsp.
// Throughput: one nibble per cycle while rsp_stall is low, set by the single response
// register. A character is sent as 2 nibbles, or 4 when the cursor wraps; set position
// as 2; init as 45; the unused mode is dropped at once with no response.
// The next request is taken in the cycle the previous one issues its last nibble.
// A stall on rsp holds the response register; the generator waits and req_stall
// stays high until the held request can issue its last nibble.
// Reset (synchronous) empties both registers, sets two_lines=1, tall_font=0 and
// homes the tracked cursor to row 0, column 0.
module char_lcd_nibble_write_sequencer #(
   parameter int COLS = clnws_pkg::COLS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  clnws_pkg::req_type                req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output clnws_pkg::rsp_type                rsp_data,
   input  logic                              csr_we,
   input  logic [clnws_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [clnws_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic               item_valid, done, take;
   clnws_pkg::req_type item_data;
   clnws_pkg::nib_type nib;

   clnws_req_reg u_req (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .done       (done),
      .item_valid (item_valid),
      .item_data  (item_data)
   );

   clnws_gen #(.COLS(COLS)) u_gen (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .item_valid (item_valid),
      .item_data  (item_data),
      .take       (take),
      .nib        (nib),
      .done       (done)
   );

   clnws_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .nib       (nib),
      .take      (take),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== src/clnws_checker.sv =====
// Port-level checks for the character LCD nibble write sequencer, with its bind.
module clnws_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input clnws_pkg::rsp_type rsp_data
);

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // nibbles of one request follow with no gap once the receiver takes them
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last |=> rsp_valid)
      else $error("gap inside a request's nibble run");

   // reset empties the block
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not empty after reset");

endmodule

bind char_lcd_nibble_write_sequencer clnws_checker u_clnws_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
